/* src/cpi_pkg.sv */
// shared constants and control types for the pair collision impulse core
// no dependencies
`default_nettype none

package cpi_pkg;

    // default coordinate width, signed q7.8
    localparam int COORD_WIDTH_DEF = 16;

    // contact distance register
    localparam int              CDIST_W     = 15;
    localparam logic [CDIST_W-1:0] CDIST_RESET = 15'd128;

    // control that travels with each request down the pipeline
    typedef struct packed {
        logic vld;
        logic hit;
        logic neg_x;
        logic neg_y;
    } cpi_ctl_t;

endpackage

`default_nettype wire

/* src/cpi_front.sv */
// front stages: differences, contact test, dot product and dividend products
// depends on cpi_pkg
`default_nettype none

module cpi_front #(
    parameter int W = cpi_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_vld,
    input  wire logic [W-1:0]                 pos_a_x,
    input  wire logic [W-1:0]                 pos_a_y,
    input  wire logic [W-1:0]                 pos_b_x,
    input  wire logic [W-1:0]                 pos_b_y,
    input  wire logic [W-1:0]                 vel_a_x,
    input  wire logic [W-1:0]                 vel_a_y,
    input  wire logic [W-1:0]                 vel_b_x,
    input  wire logic [W-1:0]                 vel_b_y,
    input  wire logic [cpi_pkg::CDIST_W-1:0]  cdist,
    output cpi_pkg::cpi_ctl_t                 ctl_o,
    output logic [((W < cpi_pkg::CDIST_W) ? W : cpi_pkg::CDIST_W) * 2
                  + W + 3 - 1:0]              px_o,
    output logic [((W < cpi_pkg::CDIST_W) ? W : cpi_pkg::CDIST_W) * 2
                  + W + 3 - 1:0]              py_o,
    output logic [((W < cpi_pkg::CDIST_W) ? W : cpi_pkg::CDIST_W) * 2:0] den_o,
    output logic [4*W-1:0]                    vel_o
);
    import cpi_pkg::*;

    localparam int DM   = (W < CDIST_W) ? W : CDIST_W;
    localparam int D2W  = 2 * DM + 1;
    localparam int DOTW = W + DM + 3;
    localparam int PW   = DM + DOTW;

    // stage 1: differences and coarse contact test
    logic signed [W:0] dx_c, dy_c, rvx_c, rvy_c;
    logic [W:0]        ndx_c, ndy_c;
    logic [W-1:0]      adx_c, ady_c;
    logic              pre_c;

    assign dx_c  = $signed({pos_b_x[W-1], pos_b_x}) - $signed({pos_a_x[W-1], pos_a_x});
    assign dy_c  = $signed({pos_b_y[W-1], pos_b_y}) - $signed({pos_a_y[W-1], pos_a_y});
    assign rvx_c = $signed({vel_b_x[W-1], vel_b_x}) - $signed({vel_a_x[W-1], vel_a_x});
    assign rvy_c = $signed({vel_b_y[W-1], vel_b_y}) - $signed({vel_a_y[W-1], vel_a_y});
    assign ndx_c = -dx_c;
    assign ndy_c = -dy_c;
    assign adx_c = dx_c[W] ? ndx_c[W-1:0] : dx_c[W-1:0];
    assign ady_c = dy_c[W] ? ndy_c[W-1:0] : dy_c[W-1:0];
    assign pre_c = ((adx_c | ady_c) != '0)
                && ({{CDIST_W{1'b0}}, adx_c} < {{W{1'b0}}, cdist})
                && ({{CDIST_W{1'b0}}, ady_c} < {{W{1'b0}}, cdist});

    logic                vld1_reg, pre1_reg;
    logic signed [DM:0]  dx1_reg, dy1_reg;
    logic [DM-1:0]       adx1_reg, ady1_reg;
    logic signed [W:0]   rvx1_reg, rvy1_reg;
    logic [CDIST_W-1:0]  cd1_reg;
    logic [4*W-1:0]      vel1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre1_reg <= pre_c;
            dx1_reg  <= dx_c[DM:0];
            dy1_reg  <= dy_c[DM:0];
            adx1_reg <= adx_c[DM-1:0];
            ady1_reg <= ady_c[DM-1:0];
            rvx1_reg <= rvx_c;
            rvy1_reg <= rvy_c;
            cd1_reg  <= cdist;
            vel1_reg <= {vel_a_x, vel_a_y, vel_b_x, vel_b_y};
        end
    end

    // stage 2: squared distance, squared contact distance, dot product
    logic [D2W-1:0]         d2_c;
    logic [2*CDIST_W-1:0]   cd2_c;
    logic signed [DOTW-1:0] dot_c;

    assign d2_c  = D2W'(adx1_reg * adx1_reg) + D2W'(ady1_reg * ady1_reg);
    assign cd2_c = cd1_reg * cd1_reg;
    assign dot_c = DOTW'(rvx1_reg * dx1_reg) + DOTW'(rvy1_reg * dy1_reg);

    logic                   vld2_reg, pre2_reg;
    logic [D2W-1:0]         d2_2_reg;
    logic [2*CDIST_W-1:0]   cd2_2_reg;
    logic signed [DOTW-1:0] dot2_reg;
    logic                   sx2_reg, sy2_reg;
    logic [DM-1:0]          adx2_reg, ady2_reg;
    logic [4*W-1:0]         vel2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre2_reg  <= pre1_reg;
            d2_2_reg  <= d2_c;
            cd2_2_reg <= cd2_c;
            dot2_reg  <= dot_c;
            sx2_reg   <= dx1_reg[DM];
            sy2_reg   <= dy1_reg[DM];
            adx2_reg  <= adx1_reg;
            ady2_reg  <= ady1_reg;
            vel2_reg  <= vel1_reg;
        end
    end

    // stage 3: fine contact test, approach test, dividend products
    localparam int CMPW = (D2W > 2 * CDIST_W) ? D2W : 2 * CDIST_W;
    logic            hit_c, dneg_c;
    logic [DOTW-1:0] ndot_c, adot_c;
    logic [CMPW-1:0] d2_ext, cd2_ext;

    assign d2_ext  = CMPW'(d2_2_reg);
    assign cd2_ext = CMPW'(cd2_2_reg);
    assign dneg_c  = dot2_reg[DOTW-1];
    assign ndot_c  = -dot2_reg;
    assign adot_c  = dneg_c ? ndot_c : dot2_reg;
    assign hit_c   = pre2_reg && (d2_ext < cd2_ext) && (dneg_c || dot2_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_o.vld <= 1'b0;
        end else if (en) begin
            ctl_o.vld <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_o.hit   <= hit_c;
            ctl_o.neg_x <= sx2_reg ^ dneg_c;
            ctl_o.neg_y <= sy2_reg ^ dneg_c;
            px_o        <= PW'(adx2_reg * adot_c);
            py_o        <= PW'(ady2_reg * adot_c);
            den_o       <= d2_2_reg;
            vel_o       <= vel2_reg;
        end
    end

endmodule

`default_nettype wire

/* src/cpi_div_step.sv */
// one restoring-division stage: settles one quotient bit for both axes
// depends on cpi_pkg
`default_nettype none

module cpi_div_step #(
    parameter int W   = cpi_pkg::COORD_WIDTH_DEF,
    parameter int BIT = 0
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire cpi_pkg::cpi_ctl_t           ctl_i,
    input  wire logic [((W < cpi_pkg::CDIST_W) ? W : cpi_pkg::CDIST_W) * 2
                       + W + 3 - 1:0]        rx_i,
    input  wire logic [((W < cpi_pkg::CDIST_W) ? W : cpi_pkg::CDIST_W) * 2
                       + W + 3 - 1:0]        ry_i,
    input  wire logic [W:0]                  qx_i,
    input  wire logic [W:0]                  qy_i,
    input  wire logic [((W < cpi_pkg::CDIST_W) ? W : cpi_pkg::CDIST_W) * 2:0] den_i,
    input  wire logic [4*W-1:0]              vel_i,
    output cpi_pkg::cpi_ctl_t                ctl_o,
    output logic [((W < cpi_pkg::CDIST_W) ? W : cpi_pkg::CDIST_W) * 2
                  + W + 3 - 1:0]             rx_o,
    output logic [((W < cpi_pkg::CDIST_W) ? W : cpi_pkg::CDIST_W) * 2
                  + W + 3 - 1:0]             ry_o,
    output logic [W:0]                       qx_o,
    output logic [W:0]                       qy_o,
    output logic [((W < cpi_pkg::CDIST_W) ? W : cpi_pkg::CDIST_W) * 2:0] den_o,
    output logic [4*W-1:0]                   vel_o
);
    import cpi_pkg::*;

    localparam int DM = (W < CDIST_W) ? W : CDIST_W;
    localparam int PW = 2 * DM + W + 3;

    // trial subtraction of the shifted divisor
    logic [PW-1:0] dsh;
    logic          gx, gy;

    assign dsh = PW'(den_i) << BIT;
    assign gx  = (rx_i >= dsh);
    assign gy  = (ry_i >= dsh);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_o.vld <= 1'b0;
        end else if (en) begin
            ctl_o.vld <= ctl_i.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_o.hit   <= ctl_i.hit;
            ctl_o.neg_x <= ctl_i.neg_x;
            ctl_o.neg_y <= ctl_i.neg_y;
            rx_o        <= gx ? (rx_i - dsh) : rx_i;
            ry_o        <= gy ? (ry_i - dsh) : ry_i;
            qx_o        <= qx_i | ((W+1)'(gx) << BIT);
            qy_o        <= qy_i | ((W+1)'(gy) << BIT);
            den_o       <= den_i;
            vel_o       <= vel_i;
        end
    end

endmodule

`default_nettype wire

/* src/cpi_back.sv */
// output stage: rounding, sign, velocity update and saturation
// depends on cpi_pkg
`default_nettype none

module cpi_back #(
    parameter int W = cpi_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire cpi_pkg::cpi_ctl_t           ctl_i,
    input  wire logic [((W < cpi_pkg::CDIST_W) ? W : cpi_pkg::CDIST_W) * 2
                       + W + 3 - 1:0]        rx_i,
    input  wire logic [((W < cpi_pkg::CDIST_W) ? W : cpi_pkg::CDIST_W) * 2
                       + W + 3 - 1:0]        ry_i,
    input  wire logic [W:0]                  qx_i,
    input  wire logic [W:0]                  qy_i,
    input  wire logic [((W < cpi_pkg::CDIST_W) ? W : cpi_pkg::CDIST_W) * 2:0] den_i,
    input  wire logic [4*W-1:0]              vel_i,
    output logic                             vld_o,
    output logic [W-1:0]                     nax_o,
    output logic [W-1:0]                     nay_o,
    output logic [W-1:0]                     nbx_o,
    output logic [W-1:0]                     nby_o,
    output logic                             hit_o
);
    import cpi_pkg::*;

    localparam int DM = (W < CDIST_W) ? W : CDIST_W;
    localparam int PW = 2 * DM + W + 3;
    localparam int SW = W + 4;

    // clamp to the signed coordinate range
    function automatic logic [W-1:0] sat_fn(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi, lo;
        hi = SW'({1'b0, {(W-1){1'b1}}});
        lo = ~hi;
        if (v > hi)      sat_fn = hi[W-1:0];
        else if (v < lo) sat_fn = lo[W-1:0];
        else             sat_fn = v[W-1:0];
    endfunction

    // round half away from zero, then apply sign
    logic [PW:0]          den_ext;
    logic [W+1:0]         mx, my;
    logic signed [SW-1:0] ix, iy, vax, vay, vbx, vby;

    assign den_ext = (PW+1)'(den_i);
    assign mx = (W+2)'(qx_i) + (W+2)'({rx_i, 1'b0} >= den_ext);
    assign my = (W+2)'(qy_i) + (W+2)'({ry_i, 1'b0} >= den_ext);
    assign ix = ctl_i.neg_x ? -$signed(SW'(mx)) : $signed(SW'(mx));
    assign iy = ctl_i.neg_y ? -$signed(SW'(my)) : $signed(SW'(my));

    assign vax = SW'($signed(vel_i[4*W-1:3*W]));
    assign vay = SW'($signed(vel_i[3*W-1:2*W]));
    assign vbx = SW'($signed(vel_i[2*W-1:W]));
    assign vby = SW'($signed(vel_i[W-1:0]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_o <= 1'b0;
        end else if (en) begin
            vld_o <= ctl_i.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_o <= ctl_i.hit;
            if (ctl_i.hit) begin
                nax_o <= sat_fn(vax + ix);
                nay_o <= sat_fn(vay + iy);
                nbx_o <= sat_fn(vbx - ix);
                nby_o <= sat_fn(vby - iy);
            end else begin
                nax_o <= vel_i[4*W-1:3*W];
                nay_o <= vel_i[3*W-1:2*W];
                nbx_o <= vel_i[2*W-1:W];
                nby_o <= vel_i[W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

/* src/pair_collision_impulse_core.sv */
// pair collision impulse core: top level, contact distance register and pipeline
// depends on cpi_pkg, cpi_front, cpi_div_step, cpi_back
`default_nettype none

// Narrow-phase impulse for one pair of circular bodies per request.
// Input channel s_*: positions and velocities of bodies A and B, signed q7.8.
// Result channel m_*: updated velocities, saturated, and impulse_applied.
// cfg_wr_en / cfg_wr_data write the contact distance (unsigned q7.8);
// write it only while no request is in flight.
// The pipeline has three front stages (differences, squares and dot
// product, dividend products), one restoring divider stage per quotient
// bit (COORD_WIDTH + 1 of them) and one output stage. Throughput is one
// request per cycle unless the receiver stalls; every stage is a register.
// Reset clears all valid bits and sets the contact distance to 0.5.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and s_ready drops; nothing is lost or repeated. A waiting result
// that is taken frees the pipeline in the same cycle, so s_ready stays
// high under back-to-back traffic.

module pair_collision_impulse_core #(
    parameter int COORD_WIDTH = cpi_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [cpi_pkg::CDIST_W-1:0]  cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [COORD_WIDTH-1:0]       s_pos_a_x,
    input  wire logic [COORD_WIDTH-1:0]       s_pos_a_y,
    input  wire logic [COORD_WIDTH-1:0]       s_pos_b_x,
    input  wire logic [COORD_WIDTH-1:0]       s_pos_b_y,
    input  wire logic [COORD_WIDTH-1:0]       s_vel_a_x,
    input  wire logic [COORD_WIDTH-1:0]       s_vel_a_y,
    input  wire logic [COORD_WIDTH-1:0]       s_vel_b_x,
    input  wire logic [COORD_WIDTH-1:0]       s_vel_b_y,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [COORD_WIDTH-1:0]            m_new_vel_a_x,
    output logic [COORD_WIDTH-1:0]            m_new_vel_a_y,
    output logic [COORD_WIDTH-1:0]            m_new_vel_b_x,
    output logic [COORD_WIDTH-1:0]            m_new_vel_b_y,
    output logic                              m_impulse_applied
);
    import cpi_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DM = (W < CDIST_W) ? W : CDIST_W;
    localparam int PW = 2 * DM + W + 3;
    localparam int DW = 2 * DM + 1;
    localparam int Q  = W + 1;

    // contact distance register
    logic [CDIST_W-1:0] cdist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cdist_reg <= CDIST_RESET;
        end else if (cfg_wr_en) begin
            cdist_reg <= cfg_wr_data;
        end
    end

    // pipeline advances unless the output holds an untaken result
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // divider chain wiring, index 0 is the front output
    cpi_ctl_t       ctl_w [0:Q];
    logic [PW-1:0]  rx_w  [0:Q];
    logic [PW-1:0]  ry_w  [0:Q];
    logic [W:0]     qx_w  [0:Q];
    logic [W:0]     qy_w  [0:Q];
    logic [DW-1:0]  den_w [0:Q];
    logic [4*W-1:0] vel_w [0:Q];

    assign qx_w[0] = '0;
    assign qy_w[0] = '0;

    cpi_front #(.W(W)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_valid),
        .pos_a_x (s_pos_a_x),
        .pos_a_y (s_pos_a_y),
        .pos_b_x (s_pos_b_x),
        .pos_b_y (s_pos_b_y),
        .vel_a_x (s_vel_a_x),
        .vel_a_y (s_vel_a_y),
        .vel_b_x (s_vel_b_x),
        .vel_b_y (s_vel_b_y),
        .cdist   (cdist_reg),
        .ctl_o   (ctl_w[0]),
        .px_o    (rx_w[0]),
        .py_o    (ry_w[0]),
        .den_o   (den_w[0]),
        .vel_o   (vel_w[0])
    );

    // one stage per quotient bit, most significant first
    for (genvar i = 0; i < Q; i++) begin : g_div
        cpi_div_step #(.W(W), .BIT(Q - 1 - i)) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_i   (ctl_w[i]),
            .rx_i    (rx_w[i]),
            .ry_i    (ry_w[i]),
            .qx_i    (qx_w[i]),
            .qy_i    (qy_w[i]),
            .den_i   (den_w[i]),
            .vel_i   (vel_w[i]),
            .ctl_o   (ctl_w[i+1]),
            .rx_o    (rx_w[i+1]),
            .ry_o    (ry_w[i+1]),
            .qx_o    (qx_w[i+1]),
            .qy_o    (qy_w[i+1]),
            .den_o   (den_w[i+1]),
            .vel_o   (vel_w[i+1])
        );
    end

    cpi_back #(.W(W)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_i   (ctl_w[Q]),
        .rx_i    (rx_w[Q]),
        .ry_i    (ry_w[Q]),
        .qx_i    (qx_w[Q]),
        .qy_i    (qy_w[Q]),
        .den_i   (den_w[Q]),
        .vel_i   (vel_w[Q]),
        .vld_o   (m_valid),
        .nax_o   (m_new_vel_a_x),
        .nay_o   (m_new_vel_a_y),
        .nbx_o   (m_new_vel_b_x),
        .nby_o   (m_new_vel_b_y),
        .hit_o   (m_impulse_applied)
    );

endmodule

`default_nettype wire
